// ===== design/dcs_pkg.sv =====
`timescale 1ns / 1ps

package dcs_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // input op codes
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_TXERR  = 3'd1;
  localparam logic [2:0] OP_MSG    = 3'd2;
  localparam logic [2:0] OP_PWRITE = 3'd3;
  localparam logic [2:0] OP_ENQ    = 3'd4;

  // received message kinds
  localparam logic [2:0] MSG_STRING = 3'd0;
  localparam logic [2:0] MSG_NUMBER = 3'd1;
  localparam logic [2:0] MSG_STATUS = 3'd2;
  localparam logic [2:0] MSG_TREADY = 3'd3;
  localparam logic [2:0] MSG_TDONE  = 3'd4;

  // result event kinds
  localparam logic [1:0] EV_ACK    = 2'd0;
  localparam logic [1:0] EV_SENT   = 2'd1;
  localparam logic [1:0] EV_FINISH = 2'd2;

  // finish outcomes
  localparam logic [2:0] OC_DONE    = 3'd0;
  localparam logic [2:0] OC_TXERR   = 3'd1;
  localparam logic [2:0] OC_TIMEOUT = 3'd2;
  localparam logic [2:0] OC_DEVICE  = 3'd3;
  localparam logic [2:0] OC_REJECT  = 3'd4;

  // result-item budget per input event, before and after a message is applied
  localparam logic [3:0] EV_LIMIT     = 4'd9;
  localparam logic [3:0] EV_LIMIT_PRE = 4'd8;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] now_ms;
    logic        tx_idle;
    logic        push_ok;
    logic [2:0]  msg_kind;
    logic [7:0]  status_code;
    logic [15:0] write_len;
    logic        write_ok;
    logic        cmd_wants_reply;
    logic        cmd_transparent;
    logic [23:0] cmd_payload_bytes;
    logic [15:0] cmd_tag;
  } in_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [2:0]  outcome;
    logic [7:0]  device_code;
    logic [15:0] result_tag;
    logic        write_accepted;
    logic        queue_full;
    logic        last;
  } out_t;

  typedef struct packed {
    logic        wants_reply;
    logic        transparent;
    logic [23:0] payload;
    logic [15:0] tag;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    cmd_t          head;
    logic [CW-1:0] count;
    logic          full;
  } q_stat_t;

  // microprogram steps and actions
  typedef enum logic [2:0] {
    U_WAIT, U_DISP, U_ADV_PRE, U_MSG, U_ADV_POST, U_ONE, U_ADV_ZERO, U_ACK
  } ustep_e;

  typedef enum logic [2:0] {
    A_WAIT, A_DISP, A_ADV, A_MSG, A_ONE, A_ACK
  } uact_e;

  typedef struct packed {
    uact_e  act;
    logic   lim_pre;
    logic   now_zero;
    ustep_e nxt;
    ustep_e alt;
  } uword_t;

  // control store: alt is taken when the step's condition holds
  function automatic uword_t ucode(input ustep_e s);
    uword_t w;
    unique case (s)
      U_WAIT:     w = '{A_WAIT, 1'b0, 1'b0, U_WAIT,     U_DISP};
      U_DISP:     w = '{A_DISP, 1'b0, 1'b0, U_ACK,      U_ACK};
      U_ADV_PRE:  w = '{A_ADV,  1'b1, 1'b0, U_MSG,      U_ADV_PRE};
      U_MSG:      w = '{A_MSG,  1'b0, 1'b0, U_ADV_POST, U_ADV_POST};
      U_ADV_POST: w = '{A_ADV,  1'b0, 1'b0, U_ACK,      U_ADV_POST};
      U_ONE:      w = '{A_ONE,  1'b0, 1'b0, U_ACK,      U_ADV_ZERO};
      U_ADV_ZERO: w = '{A_ADV,  1'b0, 1'b1, U_ACK,      U_ADV_ZERO};
      U_ACK:      w = '{A_ACK,  1'b0, 1'b0, U_WAIT,     U_WAIT};
    endcase
    return w;
  endfunction

  function automatic ustep_e dispatch(input logic [2:0] op);
    ustep_e s;
    priority case (op)
      OP_TICK:                     s = U_ADV_POST;
      OP_MSG:                      s = U_ADV_PRE;
      OP_TXERR, OP_PWRITE, OP_ENQ: s = U_ONE;
      default:                     s = U_ACK;
    endcase
    return s;
  endfunction

endpackage

// ===== design/display_command_sequencer.sv =====
`timescale 1ns / 1ps

// display command sequencer
// in channel (in_valid_i / in_ready_o / in_data_i): one event per transfer, either a
// tick, a transmit error, a received message, a payload write or an enqueue.
// out channel (out_valid_o / out_ready_i / out_data_o): for each event, zero to nine
// head-sent / finished items, then one acknowledge item with last set.
// cfg channel (cfg_valid_i / cfg_ready_o / cfg_data_i): reply timeout in ms, always
// ready; write it only while no event is in progress.
// one event is handled at a time by a small microprogram: it takes the event,
// dispatches on its op, runs the send machine step by step (each step emits at most
// one item), then emits the acknowledge. the next event can be taken in the cycle
// after its acknowledge is loaded into the output register.
// when the output register holds an item not yet taken and out_ready_i is low, the
// microprogram holds on the step that wants to emit, so nothing is lost or repeated;
// the output register is the only buffer.
// reset empties the queue, sets the send machine idle and the timeout to zero; the
// command store itself is not cleared and the block is ready right after reset.

module display_command_sequencer import dcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_SENDING, S_AWAIT_GET, S_AWAIT_READY, S_PAYLOAD, S_AWAIT_DONE
  } send_e;

  send_e         st_q, st_d;
  ustep_e        upc_q, upc_d;
  logic [31:0]   dl_q, dl_d;
  logic [23:0]   bs_q, bs_d;
  logic [3:0]    nev_q, nev_d;
  logic          acc_q, acc_d;
  logic          txf_q, txf_d;
  logic [15:0]   tmo_q;
  logic          out_valid_q;
  out_t          out_q;
  in_t           in_q;

  uword_t        ucw;
  q_stat_t       qs;
  q_ctrl_t       qctl;
  cmd_t          head;
  logic          has;
  logic          cond;
  logic          emit;
  logic          fire;
  logic          in_take;
  out_t          item;
  logic          fin;
  logic [2:0]    fin_oc;
  logic [7:0]    fin_code;
  logic [31:0]   now_sel;
  logic [31:0]   arm_val;
  logic          tmo_hit;
  logic          is_await;
  logic          is_status;
  logic [23:0]   len_ext;
  logic [23:0]   bs_sum;

  dcs_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (qctl),
    .wr_data_i ({in_q.cmd_wants_reply, in_q.cmd_transparent,
                 in_q.cmd_payload_bytes, in_q.cmd_tag}),
    .stat_o    (qs)
  );

  assign ucw         = ucode(upc_q);
  assign head        = qs.head;
  assign has         = (qs.count != '0);
  assign in_ready_o  = (upc_q == U_WAIT);
  assign in_take     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign now_sel   = ucw.now_zero ? 32'd0 : in_q.now_ms;
  assign tmo_hit   = (tmo_q != '0) && (now_sel != '0) && (now_sel >= dl_q);
  assign arm_val   = ((tmo_q != '0) && (now_sel != '0)) ? now_sel + {16'd0, tmo_q} : '1;
  assign is_await  = (st_q == S_AWAIT_GET) || (st_q == S_AWAIT_READY) ||
                     (st_q == S_AWAIT_DONE);
  assign is_status = (in_q.msg_kind == MSG_STATUS);
  assign len_ext   = {8'd0, in_q.write_len};
  assign bs_sum    = bs_q + len_ext;

  always_comb begin
    st_d     = st_q;
    dl_d     = dl_q;
    bs_d     = bs_q;
    nev_d    = nev_q;
    acc_d    = acc_q;
    txf_d    = txf_q;
    cond     = 1'b0;
    emit     = 1'b0;
    item     = '0;
    qctl     = '0;
    fin      = 1'b0;
    fin_oc   = OC_DONE;
    fin_code = '0;

    unique case (ucw.act)
      A_WAIT: begin
        cond = in_valid_i;
        if (in_valid_i) begin
          txf_d = in_data_i.tx_idle;
          nev_d = '0;
          acc_d = 1'b0;
        end
      end
      A_DISP: ;
      A_ADV: begin
        if (nev_q < (ucw.lim_pre ? EV_LIMIT_PRE : EV_LIMIT)) begin
          unique case (st_q)
            S_AWAIT_GET, S_AWAIT_READY, S_AWAIT_DONE: begin
              if (tmo_hit) begin
                fin    = 1'b1;
                fin_oc = OC_TIMEOUT;
                cond   = 1'b1;
              end
            end
            S_SENDING: begin
              if (txf_q) begin
                if (!has) begin
                  st_d = S_IDLE;
                  cond = 1'b1;
                end else if (head.wants_reply) begin
                  st_d = S_AWAIT_GET;
                  dl_d = arm_val;
                end else if (head.transparent) begin
                  st_d = S_AWAIT_READY;
                  dl_d = arm_val;
                end else begin
                  fin  = 1'b1;
                  cond = 1'b1;
                end
              end
            end
            S_PAYLOAD: begin
              if (!has) begin
                st_d = S_IDLE;
                cond = 1'b1;
              end else if (bs_q >= head.payload) begin
                st_d = S_AWAIT_DONE;
                dl_d = arm_val;
              end
            end
            default: begin
              // idle: push the head to the gateway
              if (has && txf_q) begin
                cond = 1'b1;
                if (!in_q.push_ok) begin
                  fin    = 1'b1;
                  fin_oc = OC_REJECT;
                end else begin
                  emit            = 1'b1;
                  item.event_kind = EV_SENT;
                  item.result_tag = head.tag;
                  txf_d           = 1'b0;
                  st_d            = S_SENDING;
                end
              end
            end
          endcase
        end
      end
      A_MSG: begin
        if (is_await) begin
          if (st_q == S_AWAIT_GET && in_q.msg_kind <= MSG_STATUS) begin
            fin      = 1'b1;
            fin_oc   = is_status ? OC_DEVICE : OC_DONE;
            fin_code = is_status ? in_q.status_code : 8'd0;
          end else if (st_q != S_AWAIT_GET && is_status) begin
            fin      = 1'b1;
            fin_oc   = OC_DEVICE;
            fin_code = in_q.status_code;
          end else if (st_q == S_AWAIT_READY && in_q.msg_kind == MSG_TREADY) begin
            bs_d = '0;
            st_d = S_PAYLOAD;
          end else if (st_q == S_AWAIT_DONE && in_q.msg_kind == MSG_TDONE) begin
            fin = 1'b1;
          end
        end
      end
      A_ONE: begin
        priority case (in_q.op)
          OP_TXERR: begin
            if (has) begin
              fin    = 1'b1;
              fin_oc = OC_TXERR;
            end else begin
              st_d = S_IDLE;
            end
          end
          OP_PWRITE: begin
            if (st_q == S_PAYLOAD && in_q.write_len != '0 && has && head.transparent &&
                bs_q < head.payload && len_ext <= head.payload - bs_q &&
                in_q.write_ok) begin
              bs_d  = bs_sum;
              acc_d = 1'b1;
              cond  = (bs_sum >= head.payload);
            end
          end
          OP_ENQ: begin
            if (!qs.full) begin
              qctl.push = 1'b1;
              acc_d     = 1'b1;
            end
          end
          default: ;
        endcase
      end
      A_ACK: begin
        emit                = 1'b1;
        item.event_kind     = EV_ACK;
        item.write_accepted = acc_q;
        item.queue_full     = qs.full;
        item.last           = 1'b1;
      end
      default: ;
    endcase

    if (fin) begin
      emit             = 1'b1;
      item.event_kind  = EV_FINISH;
      item.outcome     = fin_oc;
      item.device_code = fin_code;
      item.result_tag  = has ? head.tag : 16'd0;
      qctl.pop         = has;
      st_d             = S_IDLE;
    end
    if (emit) begin
      nev_d = nev_q + 1'b1;
    end

    if (ucw.act == A_DISP) begin
      upc_d = dispatch(in_q.op);
    end else begin
      upc_d = cond ? ucw.alt : ucw.nxt;
    end

    // hold a step that emits while the output register is occupied and not being taken
    fire = !emit || !out_valid_q || out_ready_i;
    if (!fire) begin
      st_d  = st_q;
      dl_d  = dl_q;
      bs_d  = bs_q;
      nev_d = nev_q;
      acc_d = acc_q;
      txf_d = txf_q;
      upc_d = upc_q;
      qctl  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      upc_q       <= U_WAIT;
      dl_q        <= '0;
      bs_q        <= '0;
      nev_q       <= '0;
      acc_q       <= 1'b0;
      txf_q       <= 1'b0;
      tmo_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      upc_q <= upc_d;
      dl_q  <= dl_d;
      bs_q  <= bs_d;
      nev_q <= nev_d;
      acc_q <= acc_d;
      txf_q <= txf_d;
      if (cfg_valid_i) begin
        tmo_q <= cfg_data_i;
      end
      if (emit && fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (emit && fire) begin
      out_q <= item;
    end
  end

endmodule

// ===== design/dcs_queue.sv =====
`timescale 1ns / 1ps

module dcs_queue import dcs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_ctrl_t ctrl_i,
  input  cmd_t    wr_data_i,
  output q_stat_t stat_o
);

  cmd_t          store [QUEUE_DEPTH];
  logic [QW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [QW-1:0] tail;
  logic [CW:0]   tail_sum;

  always_comb begin
    tail_sum = {{(CW + 1 - QW){1'b0}}, head_q} + {1'b0, count_q};
    if (tail_sum >= (CW + 1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (CW + 1)'(QUEUE_DEPTH);
    end
    tail = tail_sum[QW-1:0];

    head_d  = head_q;
    count_d = count_q;
    if (ctrl_i.pop) begin
      head_d  = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end else if (ctrl_i.push) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      store[tail] <= wr_data_i;
    end
  end

  assign stat_o.head  = store[head_q];
  assign stat_o.count = count_q;
  assign stat_o.full  = (count_q >= CW'(QUEUE_DEPTH));

endmodule

// ===== design/dcs_checker.sv =====
`timescale 1ns / 1ps

module dcs_checker import dcs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input out_t        out_data_o
);

  // a waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // one event at a time: no new input right after a transfer
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken twice in a row");

  a_last_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last == (out_data_o.event_kind == EV_ACK)))
    else $error("last not on the acknowledge");

  a_ack_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_kind != EV_ACK |->
      !out_data_o.queue_full && !out_data_o.write_accepted)
    else $error("status flags outside the acknowledge");

  a_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_kind != EV_FINISH |->
      out_data_o.outcome == OC_DONE && out_data_o.device_code == 8'd0)
    else $error("outcome outside a finish item");

endmodule

bind display_command_sequencer dcs_checker u_dcs_checker (.*);

// ===== tb/sv/tb_display_command_sequencer.sv =====
`timescale 1ns / 1ps

module tb_display_command_sequencer;
  import dcs_pkg::*;

  // codes the package leaves unnamed
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam logic [2:0] MSG_OTHER = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE, S_SENDING, S_AWAIT_GET, S_AWAIT_READY, S_PAYLOAD, S_AWAIT_DONE
  } link_state_e;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  in_t         in_data    = '0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  out_t        out_data;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data   = '0;

  display_command_sequencer DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // expected results, oldest first
  out_t due_items[$];
  int   fail_count = 0;
  bit   idle_on    = 1'b1;
  logic [31:0] clock_ms = 32'd1000;

  // shadow state of the sequencer
  logic [15:0]   tmo_ms;
  link_state_e   link_st;
  logic [31:0]   reply_due;
  logic [31:0]   bytes_done;
  cmd_t          q_store [QUEUE_DEPTH];
  logic [QW-1:0] q_head;
  int            q_count;
  int            step_events;
  logic          tx_free_now;
  logic          gw_push_ok;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void put_result(logic [1:0] kind, logic [2:0] oc, logic [7:0] code,
                                     logic [15:0] tag, logic acc, logic full, logic lst);
    out_t r;
    r.event_kind     = kind;
    r.outcome        = oc;
    r.device_code    = code;
    r.result_tag     = tag;
    r.write_accepted = acc;
    r.queue_full     = full;
    r.last           = lst;
    due_items.push_back(r);
    step_events++;
  endfunction

  function automatic void retire_head(logic [2:0] oc, logic [7:0] code);
    logic [15:0] tag;
    tag = '0;
    if (q_count != 0) begin
      tag = q_store[q_head].tag;
      q_head = q_head + 1'b1;
      q_count--;
    end
    put_result(EV_FINISH, oc, code, tag, 1'b0, 1'b0, 1'b0);
    link_st = S_IDLE;
  endfunction

  function automatic void arm_reply(logic [31:0] now);
    if (tmo_ms != 0 && now != 0) reply_due = now + {16'h0, tmo_ms};
    else reply_due = '1;
  endfunction

  function automatic void run_machine(logic [31:0] now, int limit);
    cmd_t c;
    bit   have;
    for (int g = 0; g < 4 * QUEUE_DEPTH + 8; g++) begin
      have = (q_count != 0);
      c = q_store[q_head];
      if (step_events >= limit) return;
      case (link_st)
        S_AWAIT_GET, S_AWAIT_READY, S_AWAIT_DONE: begin
          if (tmo_ms != 0 && now != 0 && now >= reply_due) begin
            retire_head(OC_TIMEOUT, '0);
            continue;
          end
          return;
        end
        S_SENDING: begin
          if (!tx_free_now) return;
          if (!have) begin
            link_st = S_IDLE;
            continue;
          end
          if (c.wants_reply) begin
            link_st = S_AWAIT_GET;
            arm_reply(now);
            return;
          end
          if (c.transparent) begin
            link_st = S_AWAIT_READY;
            arm_reply(now);
            return;
          end
          retire_head(OC_DONE, '0);
        end
        S_PAYLOAD: begin
          if (!have) begin
            link_st = S_IDLE;
            continue;
          end
          if (bytes_done >= {8'h0, c.payload}) begin
            link_st = S_AWAIT_DONE;
            arm_reply(now);
          end
          return;
        end
        default: begin
          if (!have || !tx_free_now) return;
          if (!gw_push_ok) begin
            retire_head(OC_REJECT, '0);
            continue;
          end
          put_result(EV_SENT, OC_DONE, '0, c.tag, 1'b0, 1'b0, 1'b0);
          // transmitter is busy for the rest of this event
          tx_free_now = 1'b0;
          link_st = S_SENDING;
        end
      endcase
    end
  endfunction

  function automatic void apply_msg(logic [2:0] kind, logic [7:0] code);
    link_state_e st;
    st = link_st;
    if (st != S_AWAIT_GET && st != S_AWAIT_READY && st != S_AWAIT_DONE) return;
    if (st == S_AWAIT_GET && kind <= MSG_STATUS) begin
      if (kind == MSG_STATUS) retire_head(OC_DEVICE, code);
      else retire_head(OC_DONE, '0);
      return;
    end
    if (st != S_AWAIT_GET && kind == MSG_STATUS) begin
      retire_head(OC_DEVICE, code);
      return;
    end
    if (st == S_AWAIT_READY && kind == MSG_TREADY) begin
      bytes_done = '0;
      link_st = S_PAYLOAD;
      return;
    end
    if (st == S_AWAIT_DONE && kind == MSG_TDONE) retire_head(OC_DONE, '0);
  endfunction

  function automatic bit take_payload(logic [15:0] len, logic ok);
    cmd_t        c;
    logic [31:0] need;
    if (link_st != S_PAYLOAD || len == 0 || q_count == 0) return 1'b0;
    c = q_store[q_head];
    if (!c.transparent) return 1'b0;
    need = {8'h0, c.payload};
    if (bytes_done >= need || {16'h0, len} > need - bytes_done || !ok) return 1'b0;
    bytes_done = bytes_done + {16'h0, len};
    // completion arms the done wait with time unknown
    if (bytes_done >= need) run_machine('0, int'(EV_LIMIT));
    return 1'b1;
  endfunction

  function automatic void sequence_event(in_t e);
    bit            acc;
    logic [QW-1:0] slot;
    acc = 1'b0;
    step_events = 0;
    tx_free_now = e.tx_idle;
    gw_push_ok = e.push_ok;
    case (e.op)
      OP_TICK: run_machine(e.now_ms, int'(EV_LIMIT));
      OP_TXERR: begin
        if (q_count != 0) retire_head(OC_TXERR, '0);
        else link_st = S_IDLE;
      end
      OP_MSG: begin
        run_machine(e.now_ms, int'(EV_LIMIT_PRE));
        apply_msg(e.msg_kind, e.status_code);
        run_machine(e.now_ms, int'(EV_LIMIT));
      end
      OP_PWRITE: acc = take_payload(e.write_len, e.write_ok);
      OP_ENQ: begin
        if (q_count < QUEUE_DEPTH) begin
          slot = q_head + QW'(q_count);
          q_store[slot].wants_reply = e.cmd_wants_reply;
          q_store[slot].transparent = e.cmd_transparent;
          q_store[slot].payload     = e.cmd_payload_bytes;
          q_store[slot].tag         = e.cmd_tag;
          q_count++;
          acc = 1'b1;
        end
      end
      default: ;
    endcase
    put_result(EV_ACK, OC_DONE, '0, '0, acc, q_count >= QUEUE_DEPTH, 1'b1);
  endfunction

  function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_result(out_t got);
    out_t want;
    if (due_items.size() == 0) begin
      $error("result with nothing expected: %h", got);
      fail_count++;
      return;
    end
    want = due_items.pop_front();
    cmp_field("event_kind", 32'(want.event_kind), 32'(got.event_kind));
    cmp_field("outcome", 32'(want.outcome), 32'(got.outcome));
    cmp_field("device_code", 32'(want.device_code), 32'(got.device_code));
    cmp_field("result_tag", 32'(want.result_tag), 32'(got.result_tag));
    cmp_field("write_accepted", 32'(want.write_accepted), 32'(got.write_accepted));
    cmp_field("queue_full", 32'(want.queue_full), 32'(got.queue_full));
    cmp_field("last", 32'(want.last), 32'(got.last));
  endfunction

  // inputs only move at rising edges, so the falling edge sees what the next edge takes
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
  end

  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  function automatic in_t rand_event();
    in_t          e;
    logic [127:0] bits;
    bits = {$urandom(), $urandom(), $urandom(), $urandom()};
    e = bits[$bits(in_t)-1:0];
    return e;
  endfunction

  function automatic in_t tick_ev(logic [31:0] now, logic tx, logic push);
    in_t e;
    e = rand_event();
    e.op = OP_TICK;
    e.now_ms = now;
    e.tx_idle = tx;
    e.push_ok = push;
    return e;
  endfunction

  function automatic in_t msg_ev(logic [2:0] kind, logic [7:0] code, logic [31:0] now);
    in_t e;
    e = tick_ev(now, 1'b1, 1'b1);
    e.op = OP_MSG;
    e.msg_kind = kind;
    e.status_code = code;
    return e;
  endfunction

  function automatic in_t enq_ev(logic reply, logic transp, logic [23:0] bytes,
                                 logic [15:0] tag);
    in_t e;
    e = rand_event();
    e.op = OP_ENQ;
    e.cmd_wants_reply = reply;
    e.cmd_transparent = transp;
    e.cmd_payload_bytes = bytes;
    e.cmd_tag = tag;
    return e;
  endfunction

  function automatic in_t write_ev(logic [15:0] len, logic ok);
    in_t e;
    e = rand_event();
    e.op = OP_PWRITE;
    e.write_len = len;
    e.write_ok = ok;
    return e;
  endfunction

  function automatic in_t op_ev(logic [2:0] op);
    in_t e;
    e = rand_event();
    e.op = op;
    return e;
  endfunction

  function automatic logic [31:0] next_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    // now and then jump close to the 32-bit wrap
    if (r < 8) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 80);
    else clock_ms = clock_ms + $urandom_range(0, 30);
    return clock_ms;
  endfunction

  // mostly events that move the current command along, the rest noise
  function automatic in_t pick_event();
    in_t         e;
    int          r;
    logic [31:0] left;
    e = rand_event();
    r = $urandom_range(0, 99);
    if (r < 12) return e;
    e.now_ms = next_time();
    e.tx_idle = ($urandom_range(0, 5) != 0);
    e.push_ok = ($urandom_range(0, 11) != 0);
    if (q_count < QUEUE_DEPTH && (q_count == 0 || r < 30)) begin
      e.op = OP_ENQ;
      if ($urandom_range(0, 15) == 0) e.cmd_payload_bytes = 24'($urandom_range(0, 200000));
      else e.cmd_payload_bytes = 24'($urandom_range(0, 300));
      return e;
    end
    if (r < 34) begin
      e.op = OP_TXERR;
      return e;
    end
    if (r < 44 && link_st != S_PAYLOAD) begin
      e.op = OP_TICK;
      return e;
    end
    case (link_st)
      S_AWAIT_GET: begin
        e.op = OP_MSG;
        e.msg_kind = 3'($urandom_range(0, 2));
      end
      S_AWAIT_READY: begin
        e.op = OP_MSG;
        e.msg_kind = ($urandom_range(0, 7) == 0) ? MSG_STATUS : MSG_TREADY;
      end
      S_AWAIT_DONE: begin
        e.op = OP_MSG;
        e.msg_kind = ($urandom_range(0, 7) == 0) ? MSG_STATUS : MSG_TDONE;
      end
      S_PAYLOAD: begin
        left = {8'h0, q_store[q_head].payload} - bytes_done;
        // payloads needing more than four full-length writes are dropped instead
        if (left > 32'd262140) begin
          e.op = OP_TXERR;
        end else begin
          e.op = OP_PWRITE;
          e.write_ok = ($urandom_range(0, 9) != 0);
          if (left > 32'hFFFF) e.write_len = 16'hFFFF;
          else if (left != 0 && $urandom_range(0, 2) == 0)
            e.write_len = 16'($urandom_range(1, left));
          else e.write_len = left[15:0];
        end
      end
      default: e.op = OP_TICK;
    endcase
    return e;
  endfunction

  // called at a rising edge; returns at the edge that takes the transfer
  task automatic issue_event(in_t e);
    sequence_event(e);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= e;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (due_items.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_timeout(logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    tmo_ms = v;
  endtask

  task automatic test_command_flow();
    issue_event(op_ev(OP_UNUSED));
    issue_event(tick_ev('0, 1'b1, 1'b1));
    issue_event(op_ev(OP_TXERR));
    issue_event(enq_ev(1'b0, 1'b0, '0, 16'hFFFF));
    issue_event(tick_ev('1, 1'b1, 1'b1));
    issue_event(enq_ev(1'b1, 1'b0, 24'hFFFFFF, 16'h0001));
    // plain head completes, then the reply command goes out in the same event
    issue_event(tick_ev(32'd1, 1'b1, 1'b1));
    issue_event(msg_ev(MSG_STRING, 8'h00, 32'd2));
    issue_event(enq_ev(1'b0, 1'b1, 24'd3, 16'h8000));
    issue_event(msg_ev(MSG_OTHER, 8'hFF, 32'd3));
    issue_event(msg_ev(MSG_TREADY, 8'h00, 32'd4));
    issue_event(write_ev(16'hFFFF, 1'b1));
    issue_event(write_ev(16'd0, 1'b1));
    issue_event(write_ev(16'd3, 1'b0));
    issue_event(write_ev(16'd3, 1'b1));
    issue_event(msg_ev(MSG_TDONE, 8'h00, 32'd5));
  endtask

  task automatic test_reply_timeout();
    wait_quiet();
    set_timeout(16'd10);
    issue_event(enq_ev(1'b1, 1'b0, '0, 16'h1234));
    issue_event(tick_ev(32'd100, 1'b1, 1'b1));
    issue_event(tick_ev(32'd100, 1'b1, 1'b1));
    issue_event(tick_ev(32'd110, 1'b1, 1'b1));
  endtask

  task automatic test_queue_limits();
    repeat (QUEUE_DEPTH + 1)
      issue_event(enq_ev(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         24'($urandom_range(0, 64)), 16'($urandom())));
    issue_event(op_ev(OP_TXERR));
    // every remaining command gets refused by the gateway
    issue_event(tick_ev(32'd500, 1'b1, 1'b0));
  endtask

  task automatic test_random_phase(logic [15:0] tmo, int count);
    wait_quiet();
    set_timeout(tmo);
    repeat (count) issue_event(pick_event());
  endtask

  initial begin
    link_st = S_IDLE;
    tmo_ms = '0;
    reply_due = '0;
    bytes_done = '0;
    q_head = '0;
    q_count = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_command_flow();
    test_reply_timeout();
    test_queue_limits();
    test_random_phase(16'd0, 64);
    test_random_phase(16'hFFFF, 64);
    test_random_phase(16'd1, 64);
    test_random_phase(16'd40, 72);
    idle_on = 1'b0;
    test_random_phase(16'($urandom_range(2, 100)), 72);
    wait_quiet();
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
design/dcs_pkg.sv
design/dcs_queue.sv
design/display_command_sequencer.sv
design/dcs_checker.sv
tb/sv/tb_display_command_sequencer.sv
